/* rtl/awnp_pkg.sv */
// Package with widths, constants and controller interface types of the normalize and prune block.
package awnp_pkg;

    localparam int SCORE_W     = 17;
    localparam int WEIGHT_W    = 32;
    localparam int PROD_W      = SCORE_W + WEIGHT_W;
    localparam int PRUNE_W     = 17;
    localparam int QUOT_W      = 17;
    localparam int FRAC_W      = 16;
    localparam int THRESH_W    = QUOT_W + PRUNE_W;
    localparam int COUNT_OUT_W = 7;
    localparam int DIV_CNT_W   = 5;

    localparam logic [PRUNE_W-1:0]   PRUNE_RESET = 17'd58982;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(QUOT_W - 1);

    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic div_max;
        logic thresh;
        logic rd;
        logic div_item;
        logic emit;
        logic pass;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic in_last;
        logic div_done;
        logic item_last;
    } t_sts;

endpackage

/* rtl/awnp_div.sv */
// Iterative restoring divider giving floor(p * 65536 / s) for p <= s, one quotient bit a cycle.
module awnp_div #(
    parameter int W = 55
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [W-1:0]              i_dividend,
    input  logic [W-1:0]              i_divisor,
    output logic                      o_done,
    output logic [awnp_pkg::QUOT_W-1:0] o_quot
);
    import awnp_pkg::*;

    logic [W:0]           r_rem;
    logic [W-1:0]         r_div;
    logic [QUOT_W-1:0]    r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [W:0]           w_cand;
    logic                 w_ge;

    assign w_cand = (r_cnt == '0) ? r_rem : {r_rem[W-1:0], 1'b0};
    assign w_ge   = (w_cand >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_cand - {1'b0, r_div}) : w_cand;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/awnp_dp.sv */
// Datapath with product store, sum and maximum, threshold, pruning and result registers.
module awnp_dp #(
    parameter int MAX_GROUP = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  awnp_pkg::t_cmd                    i_cmd,
    output awnp_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [awnp_pkg::PRUNE_W-1:0]      i_cfg_data,
    input  logic [awnp_pkg::SCORE_W-1:0]      i_alignment_score,
    input  logic [awnp_pkg::WEIGHT_W-1:0]     i_target_weight,
    input  logic                              i_group_last,
    output logic                              o_strobe,
    output logic [awnp_pkg::SCORE_W-1:0]      o_new_score,
    output logic                              o_was_removed,
    output logic [awnp_pkg::COUNT_OUT_W-1:0]  o_removed_count,
    output logic                              o_run_last
);
    import awnp_pkg::*;

    localparam int IDX_W = $clog2(MAX_GROUP);
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int SUM_W = PROD_W + IDX_W;

    logic [PROD_W-1:0]   r_store [MAX_GROUP];
    logic [PRUNE_W-1:0]  r_prune;
    logic [SCORE_W-1:0]  r_score;
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_last;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_rd;
    logic [SUM_W-1:0]    r_sum;
    logic [PROD_W-1:0]   r_max;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_tally;
    logic [IDX_W-1:0]    r_k;
    logic [THRESH_W-1:0] r_thresh;
    logic                r_strobe;
    logic [SCORE_W-1:0]  r_new_score;
    logic                r_removed;
    logic [COUNT_OUT_W-1:0] r_removed_count;
    logic                r_run_last;

    logic                w_full;
    logic                w_item_last;
    logic                w_div_done;
    logic [QUOT_W-1:0]   w_quot;
    logic [SUM_W-1:0]    w_dividend;
    logic [QUOT_W-1:0]   w_v;
    logic                w_prune;
    logic [CNT_W-1:0]    n_tally;

    assign w_full      = (r_count >= CNT_W'(MAX_GROUP));
    assign w_item_last = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
    assign w_dividend  = i_cmd.div_max ? SUM_W'(r_max) : SUM_W'(r_rd);

    awnp_div #(
        .W(SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_max | i_cmd.div_item),
        .i_dividend (w_dividend),
        .i_divisor  (r_sum),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_v     = (r_sum == '0) ? '0 : w_quot;
    assign w_prune = (w_v != '0) &&
                     ({{(THRESH_W-QUOT_W-FRAC_W){1'b0}}, w_v, {FRAC_W{1'b0}}} < r_thresh);
    assign n_tally = r_tally + CNT_W'(w_prune);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prune  <= PRUNE_RESET;
            r_sum    <= '0;
            r_max    <= '0;
            r_count  <= '0;
            r_tally  <= '0;
            r_k      <= '0;
            r_last   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_prune <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_last <= i_group_last;
            end
            if (i_cmd.acc && !w_full) begin
                r_sum   <= r_sum + SUM_W'(r_prod);
                r_count <= r_count + CNT_W'(1);
                if (r_prod > r_max) begin
                    r_max <= r_prod;
                end
            end
            if (i_cmd.pass || i_cmd.emit) begin
                r_strobe <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_tally <= n_tally;
                r_k     <= r_k + IDX_W'(1);
            end
            if (i_cmd.clear) begin
                r_sum   <= '0;
                r_max   <= '0;
                r_count <= '0;
                r_tally <= '0;
                r_k     <= '0;
                r_last  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_score  <= i_alignment_score;
            r_weight <= i_target_weight;
        end
        if (i_cmd.mul) begin
            r_prod <= {{(PROD_W-SCORE_W){1'b0}}, r_score} *
                      {{(PROD_W-WEIGHT_W){1'b0}}, r_weight};
        end
        if (i_cmd.thresh) begin
            r_thresh <= {{(THRESH_W-QUOT_W){1'b0}}, w_v} *
                        {{(THRESH_W-PRUNE_W){1'b0}}, r_prune};
        end
        if (i_cmd.pass) begin
            r_new_score     <= i_alignment_score;
            r_removed       <= 1'b0;
            r_removed_count <= '0;
            r_run_last      <= 1'b1;
        end else if (i_cmd.emit) begin
            r_new_score     <= w_prune ? '0 : w_v;
            r_removed       <= w_prune;
            r_removed_count <= COUNT_OUT_W'(n_tally);
            r_run_last      <= w_item_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && !w_full) begin
            r_store[r_count[IDX_W-1:0]] <= r_prod;
        end
        if (i_cmd.rd) begin
            r_rd <= r_store[r_k];
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.in_last    = r_last;
    assign o_sts.div_done   = w_div_done;
    assign o_sts.item_last  = w_item_last;

    assign o_strobe        = r_strobe;
    assign o_new_score     = r_new_score;
    assign o_was_removed   = r_removed;
    assign o_removed_count = r_removed_count;
    assign o_run_last      = r_run_last;

endmodule

/* rtl/awnp_ctrl.sv */
// Controller state machine that sequences loading, normalization and result emission.
module awnp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_group_last,
    input  awnp_pkg::t_sts i_sts,
    output awnp_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import awnp_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;
    localparam logic [3:0] S_ACC     = 4'd2;
    localparam logic [3:0] S_MAXDIV  = 4'd3;
    localparam logic [3:0] S_MAXWAIT = 4'd4;
    localparam logic [3:0] S_READ    = 4'd5;
    localparam logic [3:0] S_DIV     = 4'd6;
    localparam logic [3:0] S_WAIT    = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_group_last && i_sts.count_zero) begin
                        o_cmd.pass = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_sts.in_last ? S_MAXDIV : S_IDLE;
            end
            S_MAXDIV: begin
                o_cmd.div_max = 1'b1;
                n_state = S_MAXWAIT;
            end
            S_MAXWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.thresh = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_item = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.item_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/alignment_weight_normalize_prune.sv */
// Top level of the alignment weight normalize and prune block.
// Usage: an item (score, target weight, group_last) is accepted at a clock edge with
// start high and busy low. Items not marked last are stored as score times weight
// products; busy is high while such an item is multiplied and accumulated, so a new
// item is taken only once the previous one is stored.
// The item marked last closes the group: the block normalizes the maximum, then for
// each stored alignment reads the store, divides by the group sum and emits one
// result. Each result appears on the o_ ports for one cycle with o_strobe high and
// o_run_last marks the final one. The shared 17-step restoring divider sets the pace:
// the maximum is divided first, then each stored alignment, one division at a time,
// and busy falls in the cycle the final result is presented.
// A last item with nothing stored gives one result, its own score, the cycle after.
// Stores beyond MAX_GROUP items are dropped. The prune fraction register is written
// through i_cfg_we and i_cfg_data; the user must do so only while the block is idle
// (not enforced). Reset is synchronous and active low; it clears the group and restores
// the prune fraction to 0.90. The receiver cannot stall: every strobed result is taken.
module alignment_weight_normalize_prune #(
    parameter int MAX_GROUP = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [awnp_pkg::SCORE_W-1:0]      i_alignment_score,
    input  logic [awnp_pkg::WEIGHT_W-1:0]     i_target_weight,
    input  logic                              i_group_last,
    input  logic                              i_cfg_we,
    input  logic [awnp_pkg::PRUNE_W-1:0]      i_cfg_data,
    output logic                              o_strobe,
    output logic [awnp_pkg::SCORE_W-1:0]      o_new_score,
    output logic                              o_was_removed,
    output logic [awnp_pkg::COUNT_OUT_W-1:0]  o_removed_count,
    output logic                              o_run_last
);
    import awnp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    awnp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_group_last (i_group_last),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_busy       (busy)
    );

    awnp_dp #(
        .MAX_GROUP(MAX_GROUP)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_alignment_score (i_alignment_score),
        .i_target_weight   (i_target_weight),
        .i_group_last      (i_group_last),
        .o_strobe          (o_strobe),
        .o_new_score       (o_new_score),
        .o_was_removed     (o_was_removed),
        .o_removed_count   (o_removed_count),
        .o_run_last        (o_run_last)
    );

`ifndef SYNTHESIS
    a_pass_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pass |=> (o_strobe && o_run_last && !o_was_removed))
        else $error("single item group did not produce its result");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_was_removed) |-> (o_new_score == '0))
        else $error("removed alignment carries a nonzero score");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_cmd.emit || w_cmd.pass))
        else $error("result strobe without an emit command");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.clear) |=> !busy)
        else $error("block still busy after the final result");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the alignment weight normalize and prune block.
`timescale 1ns / 1ps

module tb_top;
    import awnp_pkg::*;

    localparam int MAX_GROUP      = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int IDLE_SETTLE    = 8;
    localparam int END_SETTLE     = 40;
    localparam int PHASE_ITEMS    = 12;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } t_align_item;

    typedef struct packed {
        logic [SCORE_W-1:0]     score;
        logic                   removed;
        logic [COUNT_OUT_W-1:0] count;
        logic                   last;
    } t_norm_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [SCORE_W-1:0]     i_alignment_score = '0;
    logic [WEIGHT_W-1:0]    i_target_weight = '0;
    logic                   i_group_last = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [PRUNE_W-1:0]     i_cfg_data = '0;
    logic                   o_strobe;
    logic [SCORE_W-1:0]     o_new_score;
    logic                   o_was_removed;
    logic [COUNT_OUT_W-1:0] o_removed_count;
    logic                   o_run_last;

    t_align_item  pending_items[$];
    t_norm_result expected_scores[$];

    logic [PROD_W-1:0]  group_products[MAX_GROUP];
    logic [PROD_W+5:0]  group_sum = '0;
    logic [PROD_W-1:0]  group_max = '0;
    int                 group_count = 0;
    logic [6:0]         removal_tally = '0;
    logic [PRUNE_W-1:0] prune_fraction_q = PRUNE_RESET;

    int           mismatch_count = 0;
    int           stall_cycles = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    t_norm_result got_result;

    alignment_weight_normalize_prune #(
        .MAX_GROUP(MAX_GROUP)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_alignment_score(i_alignment_score),
        .i_target_weight  (i_target_weight),
        .i_group_last     (i_group_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_new_score      (o_new_score),
        .o_was_removed    (o_was_removed),
        .o_removed_count  (o_removed_count),
        .o_run_last       (o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [SCORE_W-1:0] normalize_q16(input logic [PROD_W-1:0] part,
                                                         input logic [PROD_W+5:0] total);
        logic [PROD_W+FRAC_W+5:0] scaled;
        scaled = {part, 16'd0};
        return SCORE_W'(scaled / total);
    endfunction

    task automatic normalize_and_prune(input t_align_item it);
        logic [PROD_W-1:0]   prod;
        logic [SCORE_W-1:0]  best_norm;
        logic [SCORE_W-1:0]  norm;
        logic [THRESH_W-1:0] threshold;
        logic                pruned;
        int                  k;
        if (it.last && group_count == 0) begin
            expected_scores.push_back('{it.score, 1'b0, '0, 1'b1});
            return;
        end
        if (group_count < MAX_GROUP) begin
            prod = it.score * it.weight;
            group_products[group_count] = prod;
            group_sum = group_sum + prod;
            if (prod > group_max)
                group_max = prod;
            group_count++;
        end
        if (!it.last)
            return;
        best_norm = (group_sum != 0) ? normalize_q16(group_max, group_sum) : '0;
        threshold = best_norm * prune_fraction_q;
        for (k = 0; k < group_count; k++) begin
            norm = (group_sum != 0) ? normalize_q16(group_products[k], group_sum) : '0;
            pruned = (norm != 0) && ({norm, 16'd0} < threshold);
            if (pruned) begin
                norm = '0;
                removal_tally++;
            end
            expected_scores.push_back('{norm, pruned, removal_tally, k + 1 == group_count});
        end
        group_sum = '0;
        group_max = '0;
        group_count = 0;
        removal_tally = '0;
    endtask

    function automatic void note_mismatch(input string field, input longint unsigned want,
                                          input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                normalize_and_prune('{i_alignment_score, i_target_weight, i_group_last});
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!(start && busy)) begin
                if (gap_left == 0 && pending_items.size() != 0) begin
                    start <= 1'b1;
                    {i_alignment_score, i_target_weight, i_group_last} <=
                        pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_scores.size() == 0) begin
                note_mismatch("result with none expected", 0, o_new_score);
            end else begin
                got_result = expected_scores.pop_front();
                if (o_new_score !== got_result.score)
                    note_mismatch("new_score", got_result.score, o_new_score);
                if (o_was_removed !== got_result.removed)
                    note_mismatch("was_removed", got_result.removed, o_was_removed);
                if (o_removed_count !== got_result.count)
                    note_mismatch("removed_count", got_result.count, o_removed_count);
                if (o_run_last !== got_result.last)
                    note_mismatch("run_last", got_result.last, o_run_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_item(input logic [SCORE_W-1:0] score, input logic [WEIGHT_W-1:0] weight,
                              input logic last);
        pending_items.push_back('{score, weight, last});
    endtask

    function automatic logic [SCORE_W-1:0] random_score();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'd65536;
            2: return SCORE_W'($urandom_range(0, 17'h1FFFF));
            default: return SCORE_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(60000, 70000);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_group(input int n, input bit nonzero);
        logic [SCORE_W-1:0]  base;
        logic [SCORE_W-1:0]  score;
        logic [WEIGHT_W-1:0] shared_weight;
        bit                  clustered;
        int                  i;
        clustered = nonzero || ($urandom_range(0, 9) < 3);
        base = SCORE_W'($urandom_range(1000, 65536));
        shared_weight = $urandom_range(1, 32'hFFFF_FFFF);
        for (i = 0; i < n; i++) begin
            if (clustered) begin
                score = base - SCORE_W'($urandom_range(0, base / 4));
                queue_item(score, shared_weight, i == n - 1);
            end else begin
                queue_item(random_score(), random_weight(), i == n - 1);
            end
        end
    endtask

    task automatic queue_random_phase();
        int sent;
        int n;
        int pick;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                n = 1;
            else if (pick < 85)
                n = $urandom_range(2, 6);
            else
                n = $urandom_range(7, 20);
            queue_random_group(n, 1'b0);
            sent += n;
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || start || busy || expected_scores.size() != 0);
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_prune(input logic [PRUNE_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        prune_fraction_q = value;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Groups of one pass the score straight through.
        queue_item(17'd65536, 32'hFFFF_FFFF, 1'b1);
        queue_item(17'h1FFFF, 32'd0, 1'b1);
        queue_item(17'd0, 32'd12345, 1'b1);
        // Two equal maximal products split evenly.
        queue_item(17'd65536, 32'hFFFF_FFFF, 1'b0);
        queue_item(17'd65536, 32'hFFFF_FFFF, 1'b1);
        // A group whose products all vanish gives zeros.
        queue_item(17'd0, 32'hFFFF_FFFF, 1'b0);
        queue_item(17'd65536, 32'd0, 1'b0);
        queue_item(17'd0, 32'd0, 1'b1);
        // Weak alignment is pruned, a removed one stays zero, a close one survives.
        queue_item(17'd65536, 32'd65536, 1'b0);
        queue_item(17'd1000, 32'd65536, 1'b0);
        queue_item(17'd0, 32'd65536, 1'b0);
        queue_item(17'd60000, 32'd65536, 1'b1);
        queue_item(17'h1FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_item(17'd1, 32'd1, 1'b1);
        wait_idle();

        queue_random_phase();

        write_prune('0);
        queue_random_phase();
        queue_random_group(MAX_GROUP, 1'b0);

        write_prune(17'd65536);
        queue_random_phase();

        // The full group is all pruned; its two extra items overflow the store.
        write_prune(17'h1FFFF);
        queue_random_phase();
        queue_random_group(MAX_GROUP + 2, 1'b1);

        write_prune(PRUNE_W'($urandom_range(0, 17'h1FFFF)));
        queue_random_phase();

        wait_idle();
        repeat (END_SETTLE) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
